@@ hdl/pcce_pkg.sv @@
`default_nettype none

package pcce_pkg;

    localparam int MAX_SEGMENTS_DEF = 64;
    localparam int FRAC_BITS_DEF    = 16;

    localparam int DATA_W        = 32;
    localparam int CFG_W         = 7;
    localparam int SEG_USED_W    = 6;
    localparam int N_POWERS      = 4;
    localparam int N_COMPONENTS  = 3;
    localparam int COEFS_PER_SEG = N_POWERS * N_COMPONENTS;

    localparam logic [1:0] MODE_KNOT = 2'd0;
    localparam logic [1:0] MODE_COEF = 2'd1;
    localparam logic [1:0] MODE_EVAL = 2'd2;

    localparam logic KIND_ACK   = 1'b0;
    localparam logic KIND_POINT = 1'b1;

    localparam logic [1:0] POWER_TOP = 2'd3;
    localparam logic [1:0] COMP_X    = 2'd0;
    localparam logic [1:0] COMP_Y    = 2'd1;
    localparam logic [1:0] COMP_LAST = 2'd2;

    localparam logic [CFG_W-1:0] CFG_RESET = 7'd1;

    localparam logic signed [DATA_W-1:0] SAT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] SAT_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic [1:0]               mode;
        logic [6:0]               segment_index;
        logic [1:0]               power_index;
        logic [1:0]               component_index;
        logic signed [DATA_W-1:0] data_word;
        logic signed [DATA_W-1:0] param_t;
    } in_item_t;

    typedef struct packed {
        logic                     result_kind;
        logic signed [DATA_W-1:0] point_x;
        logic signed [DATA_W-1:0] point_y;
        logic signed [DATA_W-1:0] point_z;
        logic [SEG_USED_W-1:0]    segment_used;
    } out_item_t;

    typedef struct packed {
        logic capture;
        logic do_write;
        logic eval_init;
        logic scan_issue;
        logic knot_fetch;
        logic s_load;
        logic coef_issue;
        logic acc_load;
        logic mul;
        logic rnd;
        logic acc_add;
        logic point_store;
        logic comp_next;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic is_eval;
        logic scan_last;
        logic last_term;
        logic comp_last;
    } status_t;

endpackage

`default_nettype wire

@@ hdl/pcce_ram.sv @@
`default_nettype none

module pcce_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

@@ hdl/pcce_datapath.sv @@
`default_nettype none

module pcce_datapath #(
    parameter int MAX_SEGMENTS = pcce_pkg::MAX_SEGMENTS_DEF,
    parameter int FRAC_BITS    = pcce_pkg::FRAC_BITS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire pcce_pkg::in_item_t          in_item,
    input  wire logic                        cfg_we,
    input  wire logic [pcce_pkg::CFG_W-1:0]  cfg_data,
    input  wire pcce_pkg::cmd_t              cmd,
    output pcce_pkg::status_t                stat,
    output pcce_pkg::out_item_t              out_item
);

    localparam int KNOT_DEPTH = MAX_SEGMENTS + 1;
    localparam int COEF_DEPTH = MAX_SEGMENTS * pcce_pkg::COEFS_PER_SEG;
    localparam int KA         = $clog2(KNOT_DEPTH);
    localparam int CA         = $clog2(COEF_DEPTH);
    localparam int DW         = pcce_pkg::DATA_W;
    localparam logic signed [2*DW-1:0] ROUND_HALF = (2*DW)'(1) << (FRAC_BITS - 1);

    function automatic logic signed [DW-1:0] sat33(input logic signed [DW:0] v);
        logic signed [DW-1:0] r;
        if (v[DW] != v[DW-1])
        begin
            r = v[DW] ? pcce_pkg::SAT_MIN : pcce_pkg::SAT_MAX;
        end
        else
        begin
            r = v[DW-1:0];
        end
        return r;
    endfunction

    logic [pcce_pkg::CFG_W-1:0] cfg_reg;
    pcce_pkg::in_item_t         in_reg;
    logic [KA-1:0]              scan_idx_reg;
    logic [KA-1:0]              tag_reg;
    logic                       tag_valid_reg;
    logic [KA-1:0]              j_reg;
    logic signed [DW-1:0]       s_reg;
    logic signed [DW-1:0]       acc_reg;
    logic signed [2*DW-1:0]     prod_reg;
    logic signed [DW-1:0]       msat_reg;
    logic [1:0]                 pw_reg;
    logic [1:0]                 comp_reg;
    logic signed [DW-1:0]       px_reg;
    logic signed [DW-1:0]       py_reg;
    logic signed [DW-1:0]       pz_reg;
    pcce_pkg::out_item_t        out_reg;

    logic [31:0]            cfg_ext;
    logic [31:0]            n_full;
    logic [KA-1:0]          n_eff;
    logic [KA-1:0]          j_clamp;
    logic [31:0]            seg_ext;
    logic [31:0]            j_ext;
    logic                   knot_we;
    logic [KA-1:0]          knot_wr_addr;
    logic                   knot_re;
    logic [KA-1:0]          knot_rd_addr;
    logic [DW-1:0]          knot_rd;
    logic                   coef_we;
    logic [31:0]            coef_wr_full;
    logic [31:0]            coef_rd_full;
    logic [DW-1:0]          coef_rd;
    logic signed [DW-1:0]   s_val;
    logic signed [2*DW-1:0] rounded;
    logic signed [2*DW-1:0] shifted;
    logic signed [DW-1:0]   msat_val;
    logic signed [DW-1:0]   sum_val;

    always_comb
    begin
        cfg_ext = 32'(cfg_reg);
        if (cfg_ext == 32'd0)
        begin
            n_full = 32'd1;
        end
        else if (cfg_ext > 32'(MAX_SEGMENTS))
        begin
            n_full = 32'(MAX_SEGMENTS);
        end
        else
        begin
            n_full = cfg_ext;
        end
    end

    assign n_eff   = n_full[KA-1:0];
    assign j_clamp = (j_reg >= n_eff) ? (n_eff - KA'(1)) : j_reg;
    assign seg_ext = 32'(in_reg.segment_index);
    assign j_ext   = 32'(j_reg);

    assign knot_we      = cmd.do_write && (in_reg.mode == pcce_pkg::MODE_KNOT)
                          && (seg_ext < 32'(KNOT_DEPTH));
    assign knot_wr_addr = seg_ext[KA-1:0];
    assign knot_re      = cmd.scan_issue || cmd.knot_fetch;
    assign knot_rd_addr = cmd.knot_fetch ? j_clamp : scan_idx_reg;

    assign coef_we      = cmd.do_write && (in_reg.mode == pcce_pkg::MODE_COEF)
                          && (seg_ext < 32'(MAX_SEGMENTS))
                          && (32'(in_reg.component_index) < 32'(pcce_pkg::N_COMPONENTS));
    assign coef_wr_full = seg_ext * 32'(pcce_pkg::COEFS_PER_SEG)
                          + 32'(in_reg.power_index) * 32'(pcce_pkg::N_COMPONENTS)
                          + 32'(in_reg.component_index);
    assign coef_rd_full = j_ext * 32'(pcce_pkg::COEFS_PER_SEG)
                          + 32'(pw_reg) * 32'(pcce_pkg::N_COMPONENTS)
                          + 32'(comp_reg);

    pcce_ram #(
        .WIDTH (DW),
        .DEPTH (KNOT_DEPTH)
    ) u_knot_ram (
        .clk     (clk),
        .wr_en   (knot_we),
        .wr_addr (knot_wr_addr),
        .wr_data (in_reg.data_word),
        .rd_en   (knot_re),
        .rd_addr (knot_rd_addr),
        .rd_data (knot_rd)
    );

    pcce_ram #(
        .WIDTH (DW),
        .DEPTH (COEF_DEPTH)
    ) u_coef_ram (
        .clk     (clk),
        .wr_en   (coef_we),
        .wr_addr (coef_wr_full[CA-1:0]),
        .wr_data (in_reg.data_word),
        .rd_en   (cmd.coef_issue),
        .rd_addr (coef_rd_full[CA-1:0]),
        .rd_data (coef_rd)
    );

    assign s_val   = sat33({in_reg.param_t[DW-1], in_reg.param_t}
                           - {knot_rd[DW-1], knot_rd});
    assign rounded = prod_reg + ROUND_HALF;
    assign shifted = rounded >>> FRAC_BITS;

    always_comb
    begin
        if (shifted > (2*DW)'(pcce_pkg::SAT_MAX))
        begin
            msat_val = pcce_pkg::SAT_MAX;
        end
        else if (shifted < (2*DW)'(pcce_pkg::SAT_MIN))
        begin
            msat_val = pcce_pkg::SAT_MIN;
        end
        else
        begin
            msat_val = shifted[DW-1:0];
        end
    end

    assign sum_val = sat33({msat_reg[DW-1], msat_reg} + {coef_rd[DW-1], coef_rd});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg       <= pcce_pkg::CFG_RESET;
            tag_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                cfg_reg <= cfg_data;
            end
            tag_valid_reg <= cmd.scan_issue;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            in_reg <= in_item;
        end

        if (cmd.eval_init)
        begin
            scan_idx_reg <= '0;
            j_reg        <= '0;
            pw_reg       <= pcce_pkg::POWER_TOP;
            comp_reg     <= pcce_pkg::COMP_X;
        end
        else
        begin
            if (cmd.scan_issue)
            begin
                scan_idx_reg <= scan_idx_reg + KA'(1);
            end
            if (tag_valid_reg && ($signed(knot_rd) <= in_reg.param_t))
            begin
                j_reg <= tag_reg;
            end
            else if (cmd.knot_fetch)
            begin
                j_reg <= j_clamp;
            end
            if (cmd.coef_issue)
            begin
                pw_reg <= pw_reg - 2'd1;
            end
            if (cmd.comp_next)
            begin
                comp_reg <= comp_reg + 2'd1;
            end
        end

        tag_reg <= scan_idx_reg;

        if (cmd.s_load)
        begin
            s_reg <= s_val;
        end
        if (cmd.acc_load)
        begin
            acc_reg <= $signed(coef_rd);
        end
        else if (cmd.acc_add)
        begin
            acc_reg <= sum_val;
        end
        if (cmd.mul)
        begin
            prod_reg <= (2*DW)'(acc_reg) * (2*DW)'(s_reg);
        end
        if (cmd.rnd)
        begin
            msat_reg <= msat_val;
        end

        if (cmd.point_store)
        begin
            case (comp_reg)
                pcce_pkg::COMP_X: px_reg <= sum_val;
                pcce_pkg::COMP_Y: py_reg <= sum_val;
                default:          pz_reg <= sum_val;
            endcase
        end

        if (cmd.out_load)
        begin
            if (stat.is_eval)
            begin
                out_reg.result_kind  <= pcce_pkg::KIND_POINT;
                out_reg.point_x      <= px_reg;
                out_reg.point_y      <= py_reg;
                out_reg.point_z      <= pz_reg;
                out_reg.segment_used <= j_ext[pcce_pkg::SEG_USED_W-1:0];
            end
            else
            begin
                out_reg.result_kind  <= pcce_pkg::KIND_ACK;
                out_reg.point_x      <= '0;
                out_reg.point_y      <= '0;
                out_reg.point_z      <= '0;
                out_reg.segment_used <= '0;
            end
        end
    end

    assign stat.is_eval   = (in_reg.mode == pcce_pkg::MODE_EVAL);
    assign stat.scan_last = (scan_idx_reg == n_eff);
    assign stat.last_term = (pw_reg == pcce_pkg::POWER_TOP);
    assign stat.comp_last = (comp_reg == pcce_pkg::COMP_LAST);

    assign out_item = out_reg;

    a_seg_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.s_load |-> (j_reg < n_eff))
        else $error("segment not clamped before offset");

    a_store_last: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.point_store |-> (pw_reg == pcce_pkg::POWER_TOP))
        else $error("point stored before constant term");

    a_comp_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.coef_issue |-> (32'(comp_reg) < 32'(pcce_pkg::N_COMPONENTS)))
        else $error("component index out of range");

endmodule

`default_nettype wire

@@ hdl/pcce_ctrl.sv @@
`default_nettype none

module pcce_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic              out_stall,
    input  wire pcce_pkg::status_t stat,
    output pcce_pkg::cmd_t         cmd,
    output logic                   in_stall,
    output logic                   out_valid
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_DRAIN,
        ST_KNOT,
        ST_SCALC,
        ST_CLOAD,
        ST_CINIT,
        ST_MUL,
        ST_RND,
        ST_ADD,
        ST_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   in_stall_reg;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (stat.is_eval)
                begin
                    cmd.eval_init = 1'b1;
                    state_next    = ST_SCAN;
                end
                else
                begin
                    cmd.do_write = 1'b1;
                    state_next   = ST_DONE;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_issue = 1'b1;
                if (stat.scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: state_next = ST_KNOT;
            ST_KNOT:
            begin
                cmd.knot_fetch = 1'b1;
                state_next     = ST_SCALC;
            end
            ST_SCALC:
            begin
                cmd.s_load = 1'b1;
                state_next = ST_CLOAD;
            end
            ST_CLOAD:
            begin
                cmd.coef_issue = 1'b1;
                state_next     = ST_CINIT;
            end
            ST_CINIT:
            begin
                cmd.acc_load   = 1'b1;
                cmd.coef_issue = 1'b1;
                state_next     = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_RND;
            end
            ST_RND:
            begin
                cmd.rnd    = 1'b1;
                state_next = ST_ADD;
            end
            ST_ADD:
            begin
                cmd.acc_add = 1'b1;
                if (stat.last_term)
                begin
                    cmd.point_store = 1'b1;
                    if (stat.comp_last)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        cmd.comp_next = 1'b1;
                        state_next    = ST_CLOAD;
                    end
                end
                else
                begin
                    cmd.coef_issue = 1'b1;
                    state_next     = ST_MUL;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_free)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            in_stall_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            in_stall_reg  <= (state_next != ST_IDLE);
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = in_stall_reg;
    assign out_valid = out_valid_reg;

    a_capture_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> in_stall)
        else $error("input not stalled after transaction");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid || !out_stall))
        else $error("result loaded over a pending transaction");

    a_eval_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ADD && stat.last_term && stat.comp_last) |=> (state_reg == ST_DONE))
        else $error("evaluation did not finish after last component");

endmodule

`default_nettype wire

@@ hdl/piecewise_cubic_curve_evaluator_core.sv @@
`default_nettype none

// Channel  Handshake              Payload
// in       in_valid / in_stall    in_item  (pcce_pkg::in_item_t)
// out      out_valid / out_stall  out_item (pcce_pkg::out_item_t)
// cfg      cfg_valid / cfg_ready  cfg_data (segments_in_use)
//
// Write or no-op item: capture, table write (none for no-op), then ack output.
// Evaluate item: the knot scan reads one knot per cycle from the knot RAM, then
// nine multiply-round-add steps share one 32x32 multiplier. One item in flight;
// next item taken once the result is in the output register. Reset clears
// control and sets segments_in_use to 1; tables hold garbage until written.
// out_stall holds the result and blocks the next completion.

module piecewise_cubic_curve_evaluator_core #(
    parameter int MAX_SEGMENTS = pcce_pkg::MAX_SEGMENTS_DEF,
    parameter int FRAC_BITS    = pcce_pkg::FRAC_BITS_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire pcce_pkg::in_item_t         in_item,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output pcce_pkg::out_item_t             out_item,
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [pcce_pkg::CFG_W-1:0] cfg_data
);

    pcce_pkg::cmd_t    cmd;
    pcce_pkg::status_t stat;

    assign cfg_ready = 1'b1;

    pcce_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd),
        .in_stall  (in_stall),
        .out_valid (out_valid)
    );

    pcce_datapath #(
        .MAX_SEGMENTS (MAX_SEGMENTS),
        .FRAC_BITS    (FRAC_BITS)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_item  (in_item),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .cmd      (cmd),
        .stat     (stat),
        .out_item (out_item)
    );

endmodule

`default_nettype wire
